// ----- rtl/dcd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dcd_pkg: shared definitions for the directed cycle detector
//
// Holds the graph size, the vertex and count widths, the vertex colors of
// the depth-first search and the sequencer states.
// ----------------------------------------------------------------------------
package dcd_pkg;

    localparam int MAX_VERTS = 128;
    localparam int VERT_W    = 7;
    localparam int CNT_W     = VERT_W + 1;
    localparam int STK_W     = VERT_W + CNT_W;

    typedef logic [VERT_W-1:0] t_vert;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [MAX_VERTS-1:0] t_row;

    typedef enum logic [1:0] {
        COLOUR_WHITE = 2'd0,
        COLOUR_BLACK = 2'd1,
        COLOUR_GRAY  = 2'd2
    } t_colour;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_INIT,
        S_OUTER,
        S_OUTER_CHK,
        S_STEP,
        S_POP_WAIT,
        S_STEP_CHK,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

// ----- rtl/directed_cycle_detector.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// directed_cycle_detector: cycle check of a directed graph
//
// Channel   Direction  Handshake                  Payload
// input     in         i_in_valid / o_in_stall    has_edge, from/to vertex, last
// output    out        o_out_valid / i_out_stall  has_cycle
// config    in         i_cfg_wr_en                vertex_count
//
// An edge beat with has_edge set is one masked write into the adjacency RAM.
// A last beat starts the search: it paints vertices 1..n white (n = vertex_count),
// then steps through start vertices (S_OUTER, S_OUTER_CHK), adjacency probes
// (S_STEP, S_STEP_CHK) and pops (S_STEP, S_POP_WAIT), set by the registered RAM reads.
// After each search, and after reset, all 128 adjacency rows are cleared one
// row a cycle; input is stalled meanwhile. The result waits in a register.
// ----------------------------------------------------------------------------
module directed_cycle_detector
    import dcd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [VERT_W-1:0] i_cfg_wr_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic              i_has_edge,
    input  wire logic [VERT_W-1:0] i_from_vertex,
    input  wire logic [VERT_W-1:0] i_to_vertex,
    input  wire logic              i_last_edge,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic                   o_has_cycle
);

    t_state r_state, n_state;
    t_vert  r_vertex_count;
    t_cnt   r_s, n_s;
    t_vert  r_top_u, n_top_u;
    t_cnt   r_top_j, n_top_j;
    t_vert  r_j, n_j;
    t_cnt   r_depth, n_depth;
    t_vert  r_clr, n_clr;
    logic   r_cycle, n_cycle;
    logic   r_out_valid, n_out_valid;
    logic   r_has_cycle, n_has_cycle;

    t_row    adj_mem [MAX_VERTS];
    t_row    r_adj_rdata;
    logic    adj_we;
    t_vert   adj_waddr, adj_raddr;
    t_row    adj_wdata, adj_wmask;

    t_colour col_mem [MAX_VERTS];
    t_colour r_col_rdata;
    logic    col_we;
    t_vert   col_waddr, col_raddr;
    t_colour col_wdata;

    logic [STK_W-1:0] stk_mem [MAX_VERTS];
    logic [STK_W-1:0] r_stk_rdata;
    logic             stk_we;
    t_vert            stk_waddr, stk_raddr;
    logic [STK_W-1:0] stk_wdata;

    logic in_acc, out_free, s_over, j_over, edge_bit;
    t_cnt count_ext, depth_m1, depth_m2;

    assign count_ext = {1'b0, r_vertex_count};
    assign in_acc    = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign s_over    = r_s > count_ext;
    assign j_over    = r_top_j > count_ext;
    assign edge_bit  = r_adj_rdata[r_j];
    assign depth_m1  = r_depth - 1'b1;
    assign depth_m2  = r_depth - 2'd2;

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;
    assign o_has_cycle = r_has_cycle;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == {VERT_W{1'b1}}) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc && i_last_edge) n_state = S_INIT;
            end
            S_INIT: begin
                if (s_over) n_state = S_OUTER;
            end
            S_OUTER: begin
                n_state = s_over ? S_DONE : S_OUTER_CHK;
            end
            S_OUTER_CHK: begin
                n_state = (r_col_rdata == COLOUR_WHITE) ? S_STEP : S_OUTER;
            end
            S_STEP: begin
                if (!j_over)                      n_state = S_STEP_CHK;
                else if (r_depth == t_cnt'(1))    n_state = S_OUTER;
                else                              n_state = S_POP_WAIT;
            end
            S_POP_WAIT: begin
                n_state = S_STEP;
            end
            S_STEP_CHK: begin
                n_state = (edge_bit && r_col_rdata == COLOUR_GRAY) ? S_DONE : S_STEP;
            end
            S_DONE: begin
                if (out_free) n_state = S_CLEAR;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        n_s         = r_s;
        n_top_u     = r_top_u;
        n_top_j     = r_top_j;
        n_j         = r_j;
        n_depth     = r_depth;
        n_clr       = r_clr;
        n_cycle     = r_cycle;
        n_has_cycle = r_has_cycle;
        n_out_valid = r_out_valid && i_out_stall;
        adj_we      = 1'b0;
        adj_waddr   = i_from_vertex;
        adj_wdata   = '1;
        adj_wmask   = '0;
        adj_raddr   = r_top_u;
        col_we      = 1'b0;
        col_waddr   = r_s[VERT_W-1:0];
        col_wdata   = COLOUR_WHITE;
        col_raddr   = r_s[VERT_W-1:0];
        stk_we      = 1'b0;
        stk_waddr   = depth_m1[VERT_W-1:0];
        stk_wdata   = {r_top_u, r_top_j};
        stk_raddr   = depth_m2[VERT_W-1:0];
        case (r_state)
            S_CLEAR: begin
                adj_we    = 1'b1;
                adj_waddr = r_clr;
                adj_wdata = '0;
                adj_wmask = '1;
                n_clr     = r_clr + 1'b1;
            end
            S_IDLE: begin
                if (in_acc) begin
                    adj_we    = i_has_edge;
                    adj_wmask = t_row'(1) << i_to_vertex;
                    if (i_last_edge) begin
                        n_s     = t_cnt'(1);
                        n_cycle = 1'b0;
                    end
                end
            end
            S_INIT: begin
                if (s_over) begin
                    n_s = t_cnt'(1);
                end else begin
                    col_we = 1'b1;
                    n_s    = r_s + 1'b1;
                end
            end
            S_OUTER: begin
            end
            S_OUTER_CHK: begin
                if (r_col_rdata == COLOUR_WHITE) begin
                    col_we    = 1'b1;
                    col_wdata = COLOUR_GRAY;
                    n_top_u   = r_s[VERT_W-1:0];
                    n_top_j   = t_cnt'(1);
                    n_depth   = t_cnt'(1);
                end else begin
                    n_s = r_s + 1'b1;
                end
            end
            S_STEP: begin
                if (j_over) begin
                    col_we    = 1'b1;
                    col_waddr = r_top_u;
                    col_wdata = COLOUR_BLACK;
                    n_depth   = depth_m1;
                    if (r_depth == t_cnt'(1)) n_s = r_s + 1'b1;
                end else begin
                    adj_raddr = r_top_u;
                    col_raddr = r_top_j[VERT_W-1:0];
                    n_j       = r_top_j[VERT_W-1:0];
                    n_top_j   = r_top_j + 1'b1;
                end
            end
            S_POP_WAIT: begin
                n_top_u = r_stk_rdata[STK_W-1:CNT_W];
                n_top_j = r_stk_rdata[CNT_W-1:0];
            end
            S_STEP_CHK: begin
                if (edge_bit) begin
                    if (r_col_rdata == COLOUR_GRAY) begin
                        n_cycle = 1'b1;
                    end else if (r_col_rdata == COLOUR_WHITE) begin
                        stk_we    = 1'b1;
                        col_we    = 1'b1;
                        col_waddr = r_j;
                        col_wdata = COLOUR_GRAY;
                        n_top_u   = r_j;
                        n_top_j   = t_cnt'(1);
                        n_depth   = r_depth + 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_has_cycle = r_cycle;
                    n_clr       = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_vertex_count <= '0;
            r_s            <= '0;
            r_depth        <= '0;
            r_clr          <= '0;
            r_cycle        <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_s         <= n_s;
            r_depth     <= n_depth;
            r_clr       <= n_clr;
            r_cycle     <= n_cycle;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) r_vertex_count <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top_u     <= n_top_u;
        r_top_j     <= n_top_j;
        r_j         <= n_j;
        r_has_cycle <= n_has_cycle;
    end

    always_ff @(posedge i_clk) begin
        for (int b = 0; b < MAX_VERTS; b++) begin
            if (adj_we && adj_wmask[b]) adj_mem[adj_waddr][b] <= adj_wdata[b];
        end
        r_adj_rdata <= adj_mem[adj_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (col_we) col_mem[col_waddr] <= col_wdata;
        r_col_rdata <= col_mem[col_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
        r_stk_rdata <= stk_mem[stk_raddr];
    end

`ifndef NO_ASSERTIONS
    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_depth < t_cnt'(MAX_VERTS))
        else $error("search stack depth out of range");

    a_stack_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP || r_state == S_STEP_CHK || r_state == S_POP_WAIT)
        |-> r_depth != '0)
        else $error("search step with an empty stack");

    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_last_edge) |=> r_state == S_INIT)
        else $error("closing beat did not start the search");

    a_result_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (r_out_valid && r_state == S_CLEAR))
        else $error("result not posted when the search ended");
`endif

endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the directed cycle detector
//
// Loads graphs one edge beat at a time and works out the expected answer with
// its own iterative depth-first search over a copy of the adjacency matrix.
// A short directed part is followed by random graphs: acyclic graphs with and
// without a back edge, chains, random edge sets, noise, and up to three chains
// over all 127 vertices. The vertex count is rewritten between graphs while
// the block is idle. The sender works in bursts and the receiver stalls in
// changing patterns.
// ----------------------------------------------------------------------------
module testbench;

    import dcd_pkg::*;

    localparam int SETTLE_CYCLES = 300;
    localparam int RANDOM_BEATS  = 900;

    typedef enum logic [1:0] {
        STEP_BEAT,
        STEP_CFG,
        STEP_HOLD
    } t_step_kind;

    typedef struct {
        t_step_kind kind;
        logic       has_edge;
        t_vert      from_v;
        t_vert      to_v;
        logic       last;
        t_vert      cfg_value;
    } t_stim_entry;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    t_vert       i_cfg_wr_data = '0;
    logic        i_in_valid    = 1'b0;
    logic        o_in_stall;
    logic        i_has_edge    = 1'b0;
    t_vert       i_from_vertex = '0;
    t_vert       i_to_vertex   = '0;
    logic        i_last_edge   = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall   = 1'b0;
    logic        o_has_cycle;

    t_stim_entry stim_q[$];
    logic        cycle_expect_q[$];
    logic        in_taken = 1'b0;

    t_row        graph_rows [MAX_VERTS];
    int unsigned count_model = 0;

    int unsigned mismatch_count = 0;
    int unsigned beats_queued   = 0;
    int unsigned beats_loaded   = 0;
    int unsigned graphs_checked = 0;
    int unsigned cycles_seen    = 0;
    int unsigned cfg_writes     = 0;

    directed_cycle_detector uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_has_edge    (i_has_edge),
        .i_from_vertex (i_from_vertex),
        .i_to_vertex   (i_to_vertex),
        .i_last_edge   (i_last_edge),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_has_cycle   (o_has_cycle)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("testbench failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic queue_beat(input logic has, input int unsigned f, input int unsigned t,
                              input logic last);
        t_stim_entry entry;
        entry.kind      = STEP_BEAT;
        entry.has_edge  = has;
        entry.from_v    = t_vert'(f);
        entry.to_v      = t_vert'(t);
        entry.last      = last;
        entry.cfg_value = '0;
        stim_q.insert(stim_q.size(), entry);
        if (has || last) begin
            beats_queued++;
        end
    endtask

    task automatic add_cfg(input int unsigned value);
        t_stim_entry entry;
        entry.kind      = STEP_CFG;
        entry.has_edge  = 1'b0;
        entry.from_v    = '0;
        entry.to_v      = '0;
        entry.last      = 1'b0;
        entry.cfg_value = t_vert'(value);
        stim_q.insert(stim_q.size(), entry);
    endtask

    task automatic add_hold();
        t_stim_entry entry;
        entry.kind      = STEP_HOLD;
        entry.has_edge  = 1'b0;
        entry.from_v    = '0;
        entry.to_v      = '0;
        entry.last      = 1'b0;
        entry.cfg_value = '0;
        stim_q.insert(stim_q.size(), entry);
    endtask

    // Three-colour search with an explicit stack of (vertex, next neighbor).
    function automatic logic graph_has_cycle(input int unsigned count);
        t_colour     shade    [MAX_VERTS];
        t_vert       stk_vert [MAX_VERTS];
        int unsigned stk_next [MAX_VERTS];
        int unsigned depth;
        int unsigned n;
        int unsigned s;
        int unsigned u;
        int unsigned j;
        logic        found;
        n = (count > MAX_VERTS - 1) ? MAX_VERTS - 1 : count;
        for (s = 0; s < MAX_VERTS; s++) begin
            shade[s] = COLOUR_WHITE;
        end
        found = 1'b0;
        depth = 0;
        for (s = 1; s <= n && !found; s++) begin
            if (shade[s] == COLOUR_WHITE) begin
                shade[s]    = COLOUR_GRAY;
                stk_vert[0] = t_vert'(s);
                stk_next[0] = 1;
                depth       = 1;
                while (depth > 0 && !found) begin
                    u = stk_vert[depth-1];
                    j = stk_next[depth-1];
                    if (j > n) begin
                        shade[u] = COLOUR_BLACK;
                        depth--;
                    end else begin
                        stk_next[depth-1] = j + 1;
                        if (graph_rows[u][j]) begin
                            if (shade[j] == COLOUR_GRAY) begin
                                found = 1'b1;
                            end else if (shade[j] == COLOUR_WHITE && depth < MAX_VERTS) begin
                                shade[j]        = COLOUR_GRAY;
                                stk_vert[depth] = t_vert'(j);
                                stk_next[depth] = 1;
                                depth++;
                            end
                        end
                    end
                end
            end
        end
        return found;
    endfunction

    always @(posedge i_clk) begin : check_results
        logic exp_cycle;
        int   r;
        in_taken <= i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (cycle_expect_q.size() == 0) begin
                    report_mismatch("result beat with no graph pending");
                end else begin
                    exp_cycle = cycle_expect_q.pop_front();
                    if (o_has_cycle !== exp_cycle) begin
                        report_mismatch($sformatf("has_cycle got %b, expected %b",
                                                  o_has_cycle, exp_cycle));
                    end
                end
            end
            if (i_cfg_wr_en) begin
                count_model = i_cfg_wr_data;
                cfg_writes++;
            end
            if (i_in_valid && !o_in_stall) begin
                if (i_has_edge) begin
                    graph_rows[i_from_vertex][i_to_vertex] = 1'b1;
                    beats_loaded++;
                end
                if (i_last_edge) begin
                    exp_cycle = graph_has_cycle(count_model);
                    cycle_expect_q.insert(cycle_expect_q.size(), exp_cycle);
                    graphs_checked++;
                    if (exp_cycle) begin
                        cycles_seen++;
                    end
                    for (r = 0; r < MAX_VERTS; r++) begin
                        graph_rows[r] = '0;
                    end
                end
            end
        end else begin
            for (r = 0; r < MAX_VERTS; r++) begin
                graph_rows[r] = '0;
            end
        end
    end

    always @(negedge i_clk) begin : drive_beats
        logic        next_valid;
        logic        next_wr;
        int unsigned burst_left;
        int unsigned gap_left;
        int unsigned settle_left;
        if (!i_rst_n) begin
            burst_left  = $urandom_range(1, 16);
            gap_left    = 0;
            settle_left = SETTLE_CYCLES;
        end else begin
            next_valid = i_in_valid && !in_taken;
            next_wr    = 1'b0;
            if (!next_valid) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (stim_q.size() > 0) begin
                    case (stim_q[0].kind)
                        STEP_BEAT: begin
                            i_has_edge    <= stim_q[0].has_edge;
                            i_from_vertex <= stim_q[0].from_v;
                            i_to_vertex   <= stim_q[0].to_v;
                            i_last_edge   <= stim_q[0].last;
                            next_valid    = 1'b1;
                            void'(stim_q.pop_front());
                            burst_left--;
                            if (burst_left == 0) begin
                                burst_left = $urandom_range(1, 16);
                                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                            end
                        end
                        default: begin
                            if (cycle_expect_q.size() != 0) begin
                                settle_left = SETTLE_CYCLES;
                            end else if (settle_left > 0) begin
                                settle_left--;
                            end else begin
                                if (stim_q[0].kind == STEP_CFG) begin
                                    next_wr = 1'b1;
                                    i_cfg_wr_data <= stim_q[0].cfg_value;
                                end
                                void'(stim_q.pop_front());
                                settle_left = SETTLE_CYCLES;
                            end
                        end
                    endcase
                end
            end
            i_in_valid  <= next_valid;
            i_cfg_wr_en <= next_wr;
        end
    end

    always @(negedge i_clk) begin : drive_stall
        int unsigned stall_mode;
        int unsigned phase_left;
        int unsigned tick;
        logic        stall;
        tick++;
        if (phase_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            phase_left = $urandom_range(20, 200);
        end else begin
            phase_left--;
        end
        case (stall_mode)
            0:       stall = 1'b0;
            1:       stall = ($urandom_range(0, 2) == 0);
            2:       stall = ((tick % 8) < 5);
            default: stall = ($urandom_range(0, 3) != 0);
        endcase
        i_out_stall <= stall;
    end

    initial begin
        int unsigned cur_count;
        int unsigned n_sel;
        int unsigned style;
        int unsigned n_edges;
        int unsigned chain_len;
        int unsigned big_graphs;
        int unsigned g;
        int unsigned f;
        int unsigned t;
        int          k;
        int unsigned from_list[$];
        int unsigned to_list[$];
        logic        close_on_edge;

        // Directed part. The first graph runs with the count still at its reset value.
        queue_beat(1, 1, 1, 1);
        add_cfg(127);
        queue_beat(0, 7'h55, 7'h2a, 1);
        queue_beat(1, 127, 127, 1);
        queue_beat(1, 1, 2, 0);
        queue_beat(1, 1, 2, 0);
        queue_beat(1, 0, 0, 0);
        queue_beat(0, 7'h7f, 7'h7f, 0);
        queue_beat(1, 0, 5, 0);
        queue_beat(1, 2, 3, 1);
        add_cfg(3);
        queue_beat(1, 1, 2, 0);
        queue_beat(1, 2, 3, 0);
        queue_beat(1, 3, 1, 1);
        queue_beat(1, 1, 2, 0);
        queue_beat(1, 2, 3, 0);
        queue_beat(1, 3, 4, 0);
        queue_beat(1, 4, 1, 1);
        add_cfg(5);
        queue_beat(1, 1, 2, 0);
        queue_beat(1, 2, 1, 0);
        add_hold();
        add_cfg(1);
        queue_beat(0, 0, 0, 1);
        add_cfg(2);
        queue_beat(1, 2, 1, 0);
        queue_beat(1, 1, 2, 1);
        cur_count = 2;

        big_graphs = 0;
        g = 0;
        while (beats_queued < RANDOM_BEATS) begin
            g++;
            if ((g % 30) == 15 && big_graphs < 3) begin
                big_graphs++;
                add_cfg(127);
                cur_count = 127;
                for (k = 1; k < 127; k++) begin
                    queue_beat(1, k, k + 1, 0);
                end
                if ($urandom_range(0, 1)) begin
                    queue_beat(1, 127, $urandom_range(1, 127), 1);
                end else begin
                    queue_beat(0, $urandom_range(0, 127), $urandom_range(0, 127), 1);
                end
            end else begin
                if ($urandom_range(0, 99) < 60) begin
                    case ($urandom_range(0, 9))
                        0:       n_sel = 0;
                        1, 2:    n_sel = $urandom_range(11, 40);
                        default: n_sel = $urandom_range(1, 10);
                    endcase
                    add_cfg(n_sel);
                    cur_count = n_sel;
                end
                from_list.delete();
                to_list.delete();
                style = $urandom_range(0, 9);
                if (cur_count == 0) begin
                    style = 9;
                end else if (cur_count < 2 && style < 4) begin
                    style = 4;
                end
                n_edges = $urandom_range(0, (cur_count > 10) ? 24 : 2 * cur_count + 2);
                case (style)
                    0, 1, 2, 3: begin
                        for (k = 0; k < n_edges; k++) begin
                            f = $urandom_range(1, cur_count - 1);
                            t = $urandom_range(f + 1, cur_count);
                            from_list.insert(from_list.size(), f);
                            to_list.insert(to_list.size(), t);
                        end
                        if ($urandom_range(0, 9) < 4) begin
                            f = $urandom_range(1, cur_count);
                            from_list.insert(from_list.size(), f);
                            to_list.insert(to_list.size(), $urandom_range(1, f));
                        end
                    end
                    4, 5, 6: begin
                        for (k = 0; k < n_edges; k++) begin
                            from_list.insert(from_list.size(), $urandom_range(1, cur_count));
                            to_list.insert(to_list.size(), $urandom_range(1, cur_count));
                        end
                    end
                    7, 8: begin
                        chain_len = (cur_count > 30) ? 30 : cur_count;
                        for (k = 1; k < chain_len; k++) begin
                            from_list.insert(from_list.size(), k);
                            to_list.insert(to_list.size(), k + 1);
                        end
                        if ($urandom_range(0, 1)) begin
                            from_list.insert(from_list.size(), chain_len);
                            to_list.insert(to_list.size(), $urandom_range(1, chain_len));
                        end
                    end
                    default: begin
                        for (k = 0; k < n_edges; k++) begin
                            from_list.insert(from_list.size(), $urandom_range(0, 127));
                            to_list.insert(to_list.size(), $urandom_range(0, 127));
                        end
                    end
                endcase
                close_on_edge = (from_list.size() > 0) && ($urandom_range(0, 2) != 0);
                for (k = 0; k < from_list.size(); k++) begin
                    if ($urandom_range(0, 19) == 0) begin
                        queue_beat(0, $urandom_range(0, 127), $urandom_range(0, 127), 0);
                    end
                    if ($urandom_range(0, 39) == 0) begin
                        add_hold();
                    end
                    queue_beat(1, from_list[k], to_list[k],
                               close_on_edge && (k == from_list.size() - 1));
                end
                if (!close_on_edge) begin
                    queue_beat(0, $urandom_range(0, 127), $urandom_range(0, 127), 1);
                end
            end
        end

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() != 0 || i_in_valid || cycle_expect_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (cycle_expect_q.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", cycle_expect_q.size()));
        end

        $display("Checked %0d graphs, %0d of them cyclic, from %0d edge beats.",
                 graphs_checked, cycles_seen, beats_loaded);
        $display("Vertex count rewritten %0d times, from 0 up to 127; %0d mismatches.",
                 cfg_writes, mismatch_count);
        if (mismatch_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule
